### hdl/rcfp_pkg.sv
// ----------------------------------------------------------------------------
// rcfp_pkg
// Shared types, face and axis codes, register indexes and the face geometry
// lookups for the cube face pick pipeline.
// ----------------------------------------------------------------------------
package rcfp_pkg;

  localparam int IN_W  = 24;   // coordinate width
  localparam int REG_W = 23;   // register and distance width
  localparam int NFACE = 6;
  localparam int NAXIS = 3;
  localparam int QB    = 23;   // quotient bits of the distance divider

  typedef logic signed [IN_W-1:0] coord_t;
  typedef logic [REG_W-1:0]       dist_t;
  typedef logic [2:0]             face_t;
  typedef logic [1:0]             axis_t;

  localparam face_t FACE_FRONT  = 3'd0;
  localparam face_t FACE_BACK   = 3'd1;
  localparam face_t FACE_TOP    = 3'd2;
  localparam face_t FACE_BOTTOM = 3'd3;
  localparam face_t FACE_RIGHT  = 3'd4;
  localparam face_t FACE_LEFT   = 3'd5;

  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

  localparam logic REG_HALF_SIZE = 1'b0;
  localparam logic REG_MAX_DIST  = 1'b1;

  // Normal axis of a face.
  function automatic axis_t face_axis(face_t f);
    axis_t a;
    unique case (f)
      FACE_FRONT, FACE_BACK:  a = AXIS_Z;
      FACE_TOP, FACE_BOTTOM:  a = AXIS_Y;
      default:                a = AXIS_X;
    endcase
    return a;
  endfunction

  // Face plane lies at -half_size (back, bottom, left).
  function automatic logic face_neg(face_t f);
    return f[0];
  endfunction

  // The two axes in the plane normal to axis n.
  function automatic axis_t other_axis(axis_t n, logic k);
    axis_t a;
    unique case (n)
      AXIS_X:  a = k ? AXIS_Z : AXIS_Y;
      AXIS_Y:  a = k ? AXIS_Z : AXIS_X;
      default: a = k ? AXIS_Y : AXIS_X;
    endcase
    return a;
  endfunction

endpackage

### hdl/ray_cube_face_pick_top.sv
// ----------------------------------------------------------------------------
// ray_cube_face_pick_top
// Ray pick of an axis-aligned cube centered on the origin. A ray (origin,
// direction, signed fixed point) is tested against all six faces; the nearest
// face closer than max_distance wins, ties to the lower face index, and the
// result gives face, distance and the hit point in the face plane. The block
// is fully pipelined and takes one ray per cycle. The pipeline depth is set by
// the per-face restoring divider that resolves one bit of the distance per
// stage. A stall on the result side freezes the whole pipeline; empty stages
// still fill while no result waits.
// ----------------------------------------------------------------------------
module ray_cube_face_pick_top
  import rcfp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // input channel
  input  logic         in_valid,
  output logic         in_stall,
  input  coord_t       in_origin_x,
  input  coord_t       in_origin_y,
  input  coord_t       in_origin_z,
  input  coord_t       in_dir_x,
  input  coord_t       in_dir_y,
  input  coord_t       in_dir_z,
  // result channel
  output logic         out_valid,
  input  logic         out_stall,
  output logic         out_hit,
  output face_t        out_face_index,
  output coord_t       out_coord_u,
  output coord_t       out_coord_v,
  output dist_t        out_distance,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam longint HS_RAW = longint'(3) << (FRAC_BITS - 1);
  localparam longint MD_RAW = longint'(100) << FRAC_BITS;
  localparam longint W_MAX  = (longint'(1) << REG_W) - 1;
  localparam dist_t  HS_RST = REG_W'((HS_RAW > W_MAX) ? W_MAX : HS_RAW);
  localparam dist_t  MD_RST = REG_W'((MD_RAW > W_MAX) ? W_MAX : MD_RAW);

  localparam int CW   = (IN_W + FRAC_BITS > 47) ? IN_W + FRAC_BITS : 47;
  localparam int NST  = QB + 11;   // stages with a valid bit
  localparam int NCAR = QB + 9;    // stages that carry origin and direction
  localparam int SH   = QB + 8;    // stage holding the winning face

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  dist_t half_size_r, max_distance_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_size_r    <= HS_RST;
      max_distance_r <= MD_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_HALF_SIZE: half_size_r    <= pwdata[REG_W-1:0];
        REG_MAX_DIST:  max_distance_r <= pwdata[REG_W-1:0];
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_DIST) ? 32'(max_distance_r) : 32'(half_size_r);

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic           en;
  logic [NST-1:0] vld_r;

  assign en        = !vld_r[NST-1] || !out_stall;
  assign in_stall  = !en;
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // Ray carried along the pipe
  coord_t o_r [NCAR][NAXIS];
  coord_t d_r [NCAR][NAXIS];

  always_ff @(posedge clk) begin
    if (en) begin
      o_r[0][AXIS_X] <= in_origin_x;
      o_r[0][AXIS_Y] <= in_origin_y;
      o_r[0][AXIS_Z] <= in_origin_z;
      d_r[0][AXIS_X] <= in_dir_x;
      d_r[0][AXIS_Y] <= in_dir_y;
      d_r[0][AXIS_Z] <= in_dir_z;
      for (int i = 1; i < NCAR; i++) begin
        o_r[i] <= o_r[i-1];
        d_r[i] <= d_r[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: plane offsets, origin-direction cross products, |d|
  // --------------------------------------------------------------------------
  logic signed [25:0] hs26;
  logic               hs_nz;
  assign hs26  = $signed({3'b000, half_size_r});
  assign hs_nz = (half_size_r != '0);

  logic signed [25:0] num1_nxt [NFACE], num1_r [NFACE];
  logic signed [47:0] od1_nxt [NAXIS][2], od1_r [NAXIS][2], od2_r [NAXIS][2];
  logic [23:0]        dabs1_nxt [NAXIS], dabs1_r [NAXIS], dabs2_r [NAXIS], dabs3_r [NAXIS];
  logic               dz1_nxt [NAXIS], dz1_r [NAXIS];
  logic               dneg1_nxt [NAXIS], dneg1_r [NAXIS];

  always_comb begin
    for (int f = 0; f < NFACE; f++) begin
      num1_nxt[f] = face_neg(3'(f)) ? (-hs26 - 26'(o_r[0][face_axis(3'(f))]))
                                    : ( hs26 - 26'(o_r[0][face_axis(3'(f))]));
    end
    for (int n = 0; n < NAXIS; n++) begin
      for (int k = 0; k < 2; k++) begin
        od1_nxt[n][k] = 48'(o_r[0][other_axis(2'(n), 1'(k))]) * 48'(d_r[0][n]);
      end
      dabs1_nxt[n] = d_r[0][n][IN_W-1] ? 24'(-d_r[0][n]) : 24'(d_r[0][n]);
      dz1_nxt[n]   = (d_r[0][n] == '0);
      dneg1_nxt[n] = d_r[0][n][IN_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num1_r  <= num1_nxt;
      od1_r   <= od1_nxt;
      dabs1_r <= dabs1_nxt;
      dz1_r   <= dz1_nxt;
      dneg1_r <= dneg1_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: direction times offset, half size times |d_n|, sign check
  // --------------------------------------------------------------------------
  logic signed [49:0] dnum2_nxt [NFACE][2], dnum2_r [NFACE][2];
  logic [46:0]        hd2_nxt [NAXIS], hd2_r [NAXIS], hd3_r [NAXIS];
  logic               ok2_nxt [NFACE], ok2_r [NFACE], ok3_r [NFACE];
  logic [23:0]        nabs2_nxt [NFACE], nabs2_r [NFACE], nabs3_r [NFACE];

  always_comb begin
    for (int f = 0; f < NFACE; f++) begin
      for (int k = 0; k < 2; k++) begin
        dnum2_nxt[f][k] = 50'(d_r[1][other_axis(face_axis(3'(f)), 1'(k))])
                          * 50'(num1_r[f]);
      end
      // ray must point toward the plane, parallel rays miss
      ok2_nxt[f]   = hs_nz && !dz1_r[face_axis(3'(f))] && (num1_r[f] != '0)
                     && (num1_r[f][25] == dneg1_r[face_axis(3'(f))]);
      nabs2_nxt[f] = num1_r[f][25] ? 24'(-num1_r[f]) : 24'(num1_r[f]);
    end
    for (int n = 0; n < NAXIS; n++) begin
      hd2_nxt[n] = 47'(half_size_r) * 47'(dabs1_r[n]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dnum2_r <= dnum2_nxt;
      hd2_r   <= hd2_nxt;
      ok2_r   <= ok2_nxt;
      nabs2_r <= nabs2_nxt;
      od2_r   <= od1_r;
      dabs2_r <= dabs1_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: hit point in plane, scaled by d_n
  // --------------------------------------------------------------------------
  logic signed [50:0] sum3_nxt [NFACE][2], sum3_r [NFACE][2];

  always_comb begin
    for (int f = 0; f < NFACE; f++) begin
      for (int k = 0; k < 2; k++) begin
        sum3_nxt[f][k] = 51'(od2_r[face_axis(3'(f))][k]) + 51'(dnum2_r[f][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum3_r  <= sum3_nxt;
      hd3_r   <= hd2_r;
      ok3_r   <= ok2_r;
      nabs3_r <= nabs2_r;
      dabs3_r <= dabs2_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: square test, divider setup and overflow check
  // --------------------------------------------------------------------------
  logic [CW-1:0]      rem4_nxt [NFACE], rem4_r [NFACE];
  logic [23:0]        dv4_r [NFACE];
  logic               pass4_nxt [NFACE], pass4_r [NFACE];
  logic signed [50:0] hdx [NFACE];
  logic               inr [NFACE][2];
  logic               ovf [NFACE];

  always_comb begin
    for (int f = 0; f < NFACE; f++) begin
      hdx[f] = $signed(51'(hd3_r[face_axis(3'(f))]));
      for (int k = 0; k < 2; k++) begin
        inr[f][k] = (sum3_r[f][k] <= hdx[f]) && (sum3_r[f][k] >= -hdx[f]);
      end
      rem4_nxt[f]  = CW'(nabs3_r[f]) << FRAC_BITS;
      // quotient would not fit QB bits: beyond any distance bound
      ovf[f]       = rem4_nxt[f] >= (CW'(dabs3_r[face_axis(3'(f))]) << QB);
      pass4_nxt[f] = ok3_r[f] && inr[f][0] && inr[f][1] && !ovf[f];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem4_r  <= rem4_nxt;
      pass4_r <= pass4_nxt;
      for (int f = 0; f < NFACE; f++) begin
        dv4_r[f] <= dabs3_r[face_axis(3'(f))];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider: one quotient bit per stage, MSB first
  // --------------------------------------------------------------------------
  logic [CW-1:0] remd_r [QB-1][NFACE];
  logic [23:0]   dvd_r  [QB-1][NFACE];
  logic [QB-1:0] qd_r   [QB][NFACE];
  logic          passd_r [QB][NFACE];

  logic [CW-1:0] rin  [QB][NFACE];
  logic [23:0]   dvin [QB][NFACE];
  logic [QB-1:0] qin  [QB][NFACE];
  logic          pin  [QB][NFACE];
  logic [CW-1:0] dsh  [QB][NFACE];
  logic          ge   [QB][NFACE];
  logic [CW-1:0] rem_nxt [QB-1][NFACE];
  logic [QB-1:0] q_nxt   [QB][NFACE];

  always_comb begin
    for (int f = 0; f < NFACE; f++) begin
      rin[0][f]  = rem4_r[f];
      dvin[0][f] = dv4_r[f];
      qin[0][f]  = '0;
      pin[0][f]  = pass4_r[f];
    end
    for (int j = 1; j < QB; j++) begin
      for (int f = 0; f < NFACE; f++) begin
        rin[j][f]  = remd_r[j-1][f];
        dvin[j][f] = dvd_r[j-1][f];
        qin[j][f]  = qd_r[j-1][f];
        pin[j][f]  = passd_r[j-1][f];
      end
    end
    for (int j = 0; j < QB; j++) begin
      for (int f = 0; f < NFACE; f++) begin
        dsh[j][f]   = CW'(dvin[j][f]) << (QB - 1 - j);
        ge[j][f]    = rin[j][f] >= dsh[j][f];
        q_nxt[j][f] = qin[j][f] | (QB'(ge[j][f]) << (QB - 1 - j));
      end
    end
    for (int j = 0; j < QB - 1; j++) begin
      for (int f = 0; f < NFACE; f++) begin
        rem_nxt[j][f] = ge[j][f] ? (rin[j][f] - dsh[j][f]) : rin[j][f];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qd_r    <= q_nxt;
      passd_r <= pin;
      remd_r  <= rem_nxt;
      for (int j = 0; j < QB - 1; j++) begin
        dvd_r[j] <= dvin[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: face candidates; stages F to H: nearest face, lower index on tie
  // --------------------------------------------------------------------------
  logic  cand_nxt [NFACE], cand_r [NFACE];
  dist_t qe_r [NFACE];
  logic  pv_nxt [3], pv_r [3];
  dist_t pq_nxt [3], pq_r [3];
  face_t pf_nxt [3], pf_r [3];
  logic  pb [3];
  logic  gv_nxt, gv_r, g2v_r, gb;
  dist_t gq_nxt, gq_r, g2q_r;
  face_t gf_nxt, gf_r, g2f_r;
  logic  hit_nxt, hit_r, hb;
  dist_t best_nxt, best_r;
  face_t face_nxt, face_r;

  always_comb begin
    for (int f = 0; f < NFACE; f++) begin
      cand_nxt[f] = passd_r[QB-1][f] && (qd_r[QB-1][f] != '0)
                    && (qd_r[QB-1][f] < max_distance_r);
    end
    for (int p = 0; p < 3; p++) begin
      pb[p]     = cand_r[2*p+1] && (!cand_r[2*p] || (qe_r[2*p+1] < qe_r[2*p]));
      pv_nxt[p] = cand_r[2*p] || cand_r[2*p+1];
      pq_nxt[p] = pb[p] ? qe_r[2*p+1] : qe_r[2*p];
      pf_nxt[p] = pb[p] ? 3'(2*p+1) : 3'(2*p);
    end
    gb       = pv_r[1] && (!pv_r[0] || (pq_r[1] < pq_r[0]));
    gv_nxt   = pv_r[0] || pv_r[1];
    gq_nxt   = gb ? pq_r[1] : pq_r[0];
    gf_nxt   = gb ? pf_r[1] : pf_r[0];
    hb       = g2v_r && (!gv_r || (g2q_r < gq_r));
    hit_nxt  = gv_r || g2v_r;
    best_nxt = hb ? g2q_r : gq_r;
    face_nxt = hb ? g2f_r : gf_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cand_r <= cand_nxt;
      qe_r   <= qd_r[QB-1];
      pv_r   <= pv_nxt;
      pq_r   <= pq_nxt;
      pf_r   <= pf_nxt;
      gv_r   <= gv_nxt;
      gq_r   <= gq_nxt;
      gf_r   <= gf_nxt;
      g2v_r  <= pv_r[2];
      g2q_r  <= pq_r[2];
      g2f_r  <= pf_r[2];
      hit_r  <= hit_nxt;
      best_r <= best_nxt;
      face_r <= face_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage I: in-plane direction times distance
  // --------------------------------------------------------------------------
  axis_t              ua, va;
  logic signed [47:0] pu_nxt, pv2_nxt, pu_r, pv2_r;
  coord_t             ou_r, ov_r;
  logic               hiti_r;
  dist_t              besti_r;
  face_t              facei_r;

  always_comb begin
    ua      = (face_r < FACE_RIGHT) ? AXIS_X : AXIS_Z;
    va      = (face_r == FACE_TOP || face_r == FACE_BOTTOM) ? AXIS_Z : AXIS_Y;
    pu_nxt  = 48'(d_r[SH][ua]) * 48'($signed({1'b0, best_r}));
    pv2_nxt = 48'(d_r[SH][va]) * 48'($signed({1'b0, best_r}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pu_r    <= pu_nxt;
      pv2_r   <= pv2_nxt;
      ou_r    <= o_r[SH][ua];
      ov_r    <= o_r[SH][va];
      hiti_r  <= hit_r;
      besti_r <= best_r;
      facei_r <= face_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage J: floor shift, add origin, saturate; result register
  // --------------------------------------------------------------------------
  logic signed [48:0] su, sv;
  coord_t             cu_sat, cv_sat;
  logic               out_hit_r;
  face_t              out_face_r;
  coord_t             out_u_r, out_v_r;
  dist_t              out_dist_r;

  always_comb begin
    su = 49'(ou_r) + 49'(pu_r >>> FRAC_BITS);
    sv = 49'(ov_r) + 49'(pv2_r >>> FRAC_BITS);
    if (su > 49'sd8388607)        cu_sat = 24'h7FFFFF;
    else if (su < -49'sd8388608)  cu_sat = 24'h800000;
    else                          cu_sat = 24'(su);
    if (sv > 49'sd8388607)        cv_sat = 24'h7FFFFF;
    else if (sv < -49'sd8388608)  cv_sat = 24'h800000;
    else                          cv_sat = 24'(sv);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r  <= hiti_r;
      out_face_r <= hiti_r ? facei_r : FACE_FRONT;
      out_u_r    <= hiti_r ? cu_sat : '0;
      out_v_r    <= hiti_r ? cv_sat : '0;
      out_dist_r <= hiti_r ? besti_r : '0;
    end
  end

  assign out_hit        = out_hit_r;
  assign out_face_index = out_face_r;
  assign out_coord_u    = out_u_r;
  assign out_coord_v    = out_v_r;
  assign out_distance   = out_dist_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_face_index == FACE_FRONT && out_coord_u == '0
                              && out_coord_v == '0 && out_distance == '0)
    else $error("miss result carries nonzero payload");

  a_hit_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_distance != '0 && out_face_index <= FACE_LEFT)
    else $error("hit result with zero distance or bad face");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted transaction not captured");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cube face pick testbench
// Drives rays into the cube face pick pipeline with random gaps on both
// channels. Each result is checked against a behavioral model of the triangle
// tests or a fixed expectation, under several cube sizes and distance limits.
// ----------------------------------------------------------------------------
module testbench
  import rcfp_pkg::*;
();

  typedef struct {
    logic  hit;
    face_t face;
    coord_t u;
    coord_t v;
    dist_t tdist;
  } pick_t;

  typedef struct {
    coord_t o [3];
    coord_t d [3];
    bit     typed;
    pick_t  want;
  } ray_row_t;

  localparam int FB = 16;

  // Cube triangle corners in units of the half size: [triangle][corner][axis].
  localparam int CORNER [12][3][3] = '{
    '{'{ 1, 1, 1}, '{-1, 1, 1}, '{ 1,-1, 1}}, '{'{ 1,-1, 1}, '{-1, 1, 1}, '{-1,-1, 1}},
    '{'{ 1, 1,-1}, '{-1, 1,-1}, '{ 1,-1,-1}}, '{'{ 1,-1,-1}, '{-1, 1,-1}, '{-1,-1,-1}},
    '{'{-1, 1,-1}, '{-1, 1, 1}, '{ 1, 1, 1}}, '{'{-1, 1,-1}, '{ 1, 1, 1}, '{ 1, 1,-1}},
    '{'{-1,-1,-1}, '{-1,-1, 1}, '{ 1,-1, 1}}, '{'{-1,-1,-1}, '{ 1,-1, 1}, '{ 1,-1,-1}},
    '{'{ 1, 1, 1}, '{ 1,-1, 1}, '{ 1,-1,-1}}, '{'{ 1, 1, 1}, '{ 1,-1,-1}, '{ 1, 1,-1}},
    '{'{-1, 1, 1}, '{-1,-1, 1}, '{-1,-1,-1}}, '{'{-1, 1, 1}, '{-1,-1,-1}, '{-1, 1,-1}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  coord_t in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  face_t out_face_index;
  coord_t out_coord_u, out_coord_v;
  dist_t out_distance;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  longint cube_half = 98304;
  longint dist_limit = 6553600;
  pick_t pending_picks [$];
  int errors = 0;

  ray_cube_face_pick_top #(.FRAC_BITS(FB)) i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic longint clamp24(longint x);
    if (x > 8388607) return 8388607;
    if (x < -8388608) return -8388608;
    return x;
  endfunction

  // Quantized t of one triangle, 0 on a miss.
  function automatic longint triangle_t(int k, longint o [3], longint d [3]);
    longint e1 [3], e2 [3], s [3], p [3], q [3];
    longint det, den, un, vn, tn;
    for (int i = 0; i < 3; i++) begin
      e1[i] = (CORNER[k][1][i] - CORNER[k][0][i]) / 2;
      e2[i] = (CORNER[k][2][i] - CORNER[k][0][i]) / 2;
      s[i] = o[i] - cube_half * CORNER[k][0][i];
    end
    p[0] = d[1]*e2[2] - d[2]*e2[1];
    p[1] = d[2]*e2[0] - d[0]*e2[2];
    p[2] = d[0]*e2[1] - d[1]*e2[0];
    det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
    if (det == 0 || cube_half == 0) return 0;
    q[0] = s[1]*e1[2] - s[2]*e1[1];
    q[1] = s[2]*e1[0] - s[0]*e1[2];
    q[2] = s[0]*e1[1] - s[1]*e1[0];
    un = s[0]*p[0] + s[1]*p[1] + s[2]*p[2];
    vn = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
    tn = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
    if (det < 0) begin
      det = -det; un = -un; vn = -vn; tn = -tn;
    end
    den = 2 * cube_half * det;
    if (un < 0 || un > den || vn < 0 || un + vn > den) return 0;
    if (tn <= 0) return 0;
    return (tn << FB) / det;
  endfunction

  function automatic pick_t predict_pick(coord_t oc [3], coord_t dc [3]);
    longint o [3], d [3], pt [3];
    longint best, t1, t2, tf;
    int bf;
    bit found;
    pick_t r;
    best = 0; bf = 0; found = 0;
    for (int i = 0; i < 3; i++) begin
      o[i] = oc[i];
      d[i] = dc[i];
    end
    for (int f = 0; f < NFACE; f++) begin
      t1 = triangle_t(2*f, o, d);
      t2 = triangle_t(2*f + 1, o, d);
      tf = t1;
      if (tf == 0 || (t2 != 0 && t2 < tf)) tf = t2;
      if (tf != 0 && tf < dist_limit && (!found || tf < best)) begin
        found = 1; best = tf; bf = f;
      end
    end
    r = '{1'b0, FACE_FRONT, '0, '0, '0};
    if (!found) return r;
    for (int i = 0; i < 3; i++) pt[i] = clamp24(o[i] + ((d[i] * best) >>> FB));
    r.hit = 1'b1;
    r.face = face_t'(bf);
    r.tdist = dist_t'(best);
    if (r.face == FACE_FRONT || r.face == FACE_BACK) begin
      r.u = coord_t'(pt[0]); r.v = coord_t'(pt[1]);
    end else if (r.face == FACE_TOP || r.face == FACE_BOTTOM) begin
      r.u = coord_t'(pt[0]); r.v = coord_t'(pt[2]);
    end else begin
      r.u = coord_t'(pt[2]); r.v = coord_t'(pt[1]);
    end
    return r;
  endfunction

  task automatic reg_write(logic index, longint value);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {index, 2'b00}; pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (index == REG_HALF_SIZE) cube_half = value & 23'h7FFFFF;
    else dist_limit = value & 23'h7FFFFF;
  endtask

  // Wait for every outstanding transaction, then let the pipe empty.
  task automatic drain();
    int n;
    n = 0;
    while (pending_picks.size() != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic send_ray(ray_row_t row);
    int g;
    in_valid <= 1'b1;
    in_origin_x <= row.o[0]; in_origin_y <= row.o[1]; in_origin_z <= row.o[2];
    in_dir_x <= row.d[0]; in_dir_y <= row.d[1]; in_dir_z <= row.d[2];
    do @(posedge clk); while (in_stall);
    pending_picks.push_back(row.typed ? row.want : predict_pick(row.o, row.d));
    g = $urandom_range(0, 99);
    if (g >= 60) begin
      in_valid <= 1'b0;
      repeat (g >= 92 ? $urandom_range(10, 40) : $urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic longint rand_signed(longint span);
    return longint'($urandom_range(0, 32'(2*span))) - span;
  endfunction

  function automatic ray_row_t random_ray();
    ray_row_t r;
    longint tgt, o, d [3];
    int kind, sh;
    r.typed = 0;
    kind = $urandom_range(0, 9);
    sh = $urandom_range(0, 4);
    for (int i = 0; i < 3; i++) begin
      if (kind < 6) begin
        // aim at a point in or on the cube
        o = rand_signed(1 << 21);
        tgt = rand_signed(cube_half > 8388607 ? 8388607 : cube_half);
        d[i] = tgt - o;
        while (d[i] > 8388607 || d[i] < -8388608) d[i] = d[i] / 2;
        d[i] = d[i] >>> sh;
        if (kind == 5 && i == $urandom_range(0, 2)) d[i] = 0;
      end else begin
        o = rand_signed(kind < 8 ? (1 << 19) : 8388607);
        d[i] = kind == 9 ? longint'($signed(24'($urandom))) : rand_signed(1 << 17);
        if (kind == 6 && $urandom_range(0, 1)) d[i] = 0;
      end
      r.o[i] = coord_t'(o);
      r.d[i] = coord_t'(d[i]);
    end
    return r;
  endfunction

  // Result side back-pressure with changing density.
  int stall_pct = 0;
  int stall_cnt = 0;
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 256 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 10;
        2: stall_pct <= 50;
        default: stall_pct <= 90;
      endcase
    end
    out_stall <= $urandom_range(0, 99) < stall_pct;
  end

  always @(posedge clk) begin
    pick_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_picks.size() == 0) begin
        $error("result with no ray outstanding");
        errors++;
      end else begin
        w = pending_picks.pop_front();
        if (out_hit !== w.hit) begin
          $error("hit: expected %0d, got %0d", w.hit, out_hit); errors++;
        end
        if (out_face_index !== w.face) begin
          $error("face_index: expected %0d, got %0d", w.face, out_face_index); errors++;
        end
        if (out_coord_u !== w.u) begin
          $error("coord_u: expected %0d, got %0d", w.u, out_coord_u); errors++;
        end
        if (out_coord_v !== w.v) begin
          $error("coord_v: expected %0d, got %0d", w.v, out_coord_v); errors++;
        end
        if (out_distance !== w.tdist) begin
          $error("distance: expected %0d, got %0d", w.tdist, out_distance); errors++;
        end
      end
    end
  end

  localparam longint ONE = 1 << FB;
  localparam pick_t MISS = '{1'b0, FACE_FRONT, '0, '0, '0};

  ray_row_t directed_rays [] = '{
    '{'{0, 0, 5*ONE}, '{0, 0, -ONE}, 1, '{1'b1, FACE_FRONT, '0, '0, 23'd229376}},
    '{'{0, 0, 0}, '{ONE, 0, 0}, 1, '{1'b1, FACE_RIGHT, '0, '0, 23'd98304}},
    '{'{0, 0, 0}, '{0, 0, 0}, 1, MISS},
    '{'{0, 0, 120*ONE}, '{0, 0, -ONE}, 1, MISS},
    '{'{0, 0, -5*ONE}, '{0, 0, ONE}, 0, MISS},
    '{'{0, 5*ONE, 0}, '{0, -ONE, 0}, 0, MISS},
    '{'{0, -5*ONE, 0}, '{0, ONE, 0}, 0, MISS},
    '{'{-5*ONE, 0, 0}, '{ONE, 0, 0}, 0, MISS},
    '{'{5*ONE, ONE/2, ONE/3}, '{-ONE, 0, 0}, 0, MISS},
    '{'{5*ONE, 98304, 98304}, '{-ONE, 0, 0}, 0, MISS},
    '{'{5*ONE, 5*ONE, 5*ONE}, '{-ONE, -ONE, -ONE}, 0, MISS},
    '{'{0, 5*ONE, 0}, '{ONE, 0, 0}, 0, MISS},
    '{'{0, 0, 5*ONE}, '{0, 0, ONE}, 0, MISS},
    '{'{-8388608, -8388608, -8388608}, '{8388607, 8388607, 8388607}, 0, MISS},
    '{'{8388607, 8388607, 8388607}, '{-8388608, -8388608, -8388608}, 0, MISS},
    '{'{8388607, 0, 0}, '{-8388608, 0, 0}, 0, MISS},
    '{'{0, 0, 8388607}, '{1, 0, -8388608}, 0, MISS},
    '{'{0, 0, 5*ONE}, '{0, 0, -1}, 0, MISS},
    '{'{0, 0, 98305}, '{0, 0, -8388608}, 0, MISS},
    '{'{3*ONE, 3*ONE, 0}, '{-ONE, -ONE, 0}, 0, MISS}
  };

  longint phase_half [7] = '{98304, 0, 8388607, 65536, -1, 1, 4096};
  longint phase_limit [7] = '{6553600, 6553600, 8388607, 0, -1, 8388607, 300000};

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rays[i]) send_ray(directed_rays[i]);
    for (int ph = 0; ph < 7; ph++) begin
      if (ph != 0) begin
        in_valid <= 1'b0;
        drain();
        reg_write(REG_HALF_SIZE, phase_half[ph] < 0 ? $urandom_range(0, 8388607) :
                  phase_half[ph]);
        reg_write(REG_MAX_DIST, phase_limit[ph] < 0 ? $urandom_range(0, 8388607) :
                  phase_limit[ph]);
      end
      for (int n = 0; n < 170; n++) begin
        if (n == 85) begin
          in_valid <= 1'b0;
          drain();
        end
        send_ray(random_ray());
      end
    end
    in_valid <= 1'b0;
    drain();
    if (errors == 0 && pending_picks.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
